@@ rtl/hduart_pkg.sv @@
`default_nettype none
package hduart_pkg;

    // event codes carried on the input channel
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_EDGE = 2'd1;
    localparam logic [1:0] CMD_SEND = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_ENABLE       = 3'd0;
    localparam logic [2:0] CFG_BIT_COMPARE  = 3'd1;
    localparam logic [2:0] CFG_FIRST_SAMPLE = 3'd2;
    localparam logic [2:0] CFG_CRLF_EXPAND  = 3'd3;
    localparam logic [2:0] CFG_ECHO_ENABLE  = 3'd4;

    localparam logic [7:0] BIT_COMPARE_RST  = 8'd94;
    localparam logic [7:0] FIRST_SAMPLE_RST = 8'd125;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] MASK_FIRST = 8'h01;
    localparam logic [7:0] MASK_LAST  = 8'h80;
    localparam logic [7:0] MASK_NONE  = 8'h00;

    typedef struct packed {
        logic [1:0] cmd;
        logic       rx_level;
        logic [7:0] tx_byte;
    } event_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] index;
        logic [7:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic       tx_line;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       status;
        logic       add_lf;
    } evt_result_t;

endpackage
`default_nettype wire

@@ rtl/half_duplex_uart_with_rx_preempt_top.sv @@
// Half-duplex 8N1 uart channel driven by timer ticks, one event per transaction.
// Input stream: s_tuser carries the event (tick, rx falling edge, send request),
// s_tdata the rx level and the byte to send. Every event yields one result on
// the m_ stream; a received carriage return with line feed expansion on yields
// a second result carrying the line feed, and only the final one has m_tlast.
// Configuration registers are written over the cfg_ channel, which is always
// ready; writes are meant for when the stream is idle.
// An accepted event is held in the input register, processed by the core once
// the output register is free, and its first result is registered there.
// Throughput: one event per cycle while m_tready is high; an event with an
// inserted line feed holds the output until the line feed has also left.
// The send queue sits in a single-port-write, registered-read ram whose head
// entry is prefetched.
// When the receiver stalls the output register holds, one further event waits
// in the input register, and s_tready falls.
// Reset (aresetn low, synchronous) clears both stream stages, restores the
// register defaults, frees the line with tx high and empties the queue.
`default_nettype none
module half_duplex_uart_with_rx_preempt_top #(
    parameter int TX_QUEUE_DEPTH = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // rx_level [0], tx_byte [8:1], zero [15:9]
    input  wire logic [1:0]  s_tuser,   // cmd [1:0]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // tx_line [0], rx_byte [8:1], status [9], zero [15:10]
    output logic             m_tuser,   // rx_valid [0]
    output logic             m_tlast,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic                    in_valid_reg;
    hduart_pkg::event_t      in_evt_reg;
    logic                    out_valid_reg;
    hduart_pkg::evt_result_t out_res_reg;
    logic                    out_last_reg;
    logic                    lf_pend_reg;
    logic                    out_free;
    logic                    evt_take;
    hduart_pkg::cfg_wr_t     cfg;
    hduart_pkg::evt_result_t core_res;

    assign cfg_ready = 1'b1;
    assign cfg       = {cfg_valid, cfg_index, cfg_data};

    // output register is free once its last result leaves
    assign out_free = !out_valid_reg || (m_tready && !lf_pend_reg);
    assign evt_take = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    hduart_core #(
        .TX_QUEUE_DEPTH (TX_QUEUE_DEPTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .evt_valid (evt_take),
        .evt       (in_evt_reg),
        .res       (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lf_pend_reg   <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (evt_take) begin
                in_valid_reg <= 1'b0;
            end

            if (evt_take) begin
                out_valid_reg <= 1'b1;
                lf_pend_reg   <= core_res.add_lf;
            end else if (m_tvalid && m_tready) begin
                if (lf_pend_reg) begin
                    lf_pend_reg <= 1'b0;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end
        end

        if (s_tvalid && s_tready) begin
            in_evt_reg.cmd      <= s_tuser;
            in_evt_reg.rx_level <= s_tdata[0];
            in_evt_reg.tx_byte  <= s_tdata[8:1];
        end

        if (evt_take) begin
            out_res_reg  <= core_res;
            out_last_reg <= !core_res.add_lf;
        end else if (m_tvalid && m_tready && lf_pend_reg) begin
            // inserted line feed keeps the tx level of its event
            out_res_reg.rx_valid <= 1'b1;
            out_res_reg.rx_byte  <= hduart_pkg::CHAR_LF;
            out_res_reg.status   <= 1'b0;
            out_res_reg.add_lf   <= 1'b0;
            out_last_reg         <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.status, out_res_reg.rx_byte, out_res_reg.tx_line};
    assign m_tuser  = out_res_reg.rx_valid;
    assign m_tlast  = out_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && lf_pend_reg |-> !m_tlast)
        else $error("result with a line feed pending marked last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && lf_pend_reg |=>
            m_tvalid && m_tlast && m_tuser && (m_tdata[8:1] == hduart_pkg::CHAR_LF))
        else $error("inserted line feed missing after carriage return");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_evt_reg))
        else $error("waiting event lost while output stalled");

endmodule
`default_nettype wire

@@ rtl/hduart_ram.sv @@
`default_nettype none
module hduart_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

@@ rtl/hduart_core.sv @@
`default_nettype none
module hduart_core #(
    parameter int TX_QUEUE_DEPTH = 128,
    localparam int QW = (TX_QUEUE_DEPTH > 1) ? $clog2(TX_QUEUE_DEPTH) : 1,
    localparam int CW = $clog2(TX_QUEUE_DEPTH + 1)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire hduart_pkg::cfg_wr_t    cfg,
    input  wire logic                   evt_valid,
    input  wire hduart_pkg::event_t     evt,
    output hduart_pkg::evt_result_t     res
);

    typedef enum logic [1:0] {
        MODE_FREE,
        MODE_TX,
        MODE_TX_STOP,
        MODE_RX
    } mode_t;

    localparam logic [QW-1:0] LAST_ADDR = QW'(TX_QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TX_QUEUE_DEPTH);

    logic       enable_reg, enable_next;
    logic [7:0] bit_compare_reg, bit_compare_next;
    logic [7:0] first_sample_reg, first_sample_next;
    logic       crlf_expand_reg, crlf_expand_next;
    logic       echo_enable_reg, echo_enable_next;

    mode_t      mode_reg, mode_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [7:0] compare_reg, compare_next;
    logic [7:0] bit_mask_reg, bit_mask_next;
    logic [7:0] shift_reg, shift_next;
    logic       tx_level_reg, tx_level_next;
    logic [QW-1:0] head_reg, head_next;
    logic [QW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    logic          bypass_reg;
    logic [7:0]    bypass_data_reg;
    logic [7:0]    ram_rd_data;
    logic [7:0]    head_data;
    logic          push_en;
    logic [7:0]    push_data;

    // head entry of the queue: a write that landed on the head address wins
    assign head_data = bypass_reg ? bypass_data_reg : ram_rd_data;

    hduart_ram #(
        .WIDTH (8),
        .DEPTH (TX_QUEUE_DEPTH)
    ) u_queue_ram (
        .aclk    (aclk),
        .wr_en   (push_en),
        .wr_addr (tail_reg),
        .wr_data (push_data),
        .rd_addr (head_next),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        logic       send_req;
        logic [7:0] send_b;
        logic       pop_en;
        logic       start_en;
        logic [7:0] start_b;
        logic [7:0] shift_v;
        logic       got;
        logic [7:0] rx_b;
        logic       status;

        send_req = 1'b0;
        send_b   = evt.tx_byte;
        pop_en   = 1'b0;
        start_en = 1'b0;
        start_b  = evt.tx_byte;
        shift_v  = shift_reg;
        got      = 1'b0;
        rx_b     = 8'd0;
        status   = 1'b0;
        push_en  = 1'b0;
        push_data = evt.tx_byte;

        enable_next       = enable_reg;
        bit_compare_next  = bit_compare_reg;
        first_sample_next = first_sample_reg;
        crlf_expand_next  = crlf_expand_reg;
        echo_enable_next  = echo_enable_reg;
        mode_next         = mode_reg;
        tick_count_next   = tick_count_reg;
        compare_next      = compare_reg;
        bit_mask_next     = bit_mask_reg;
        shift_next        = shift_reg;
        tx_level_next     = tx_level_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;

        if (cfg.valid) begin
            case (cfg.index)
                hduart_pkg::CFG_ENABLE: begin
                    enable_next = cfg.data[0];
                    // reopening the channel frees the line, queue is kept
                    if (cfg.data[0] && !enable_reg) begin
                        mode_next       = MODE_FREE;
                        tx_level_next   = 1'b1;
                        tick_count_next = 8'd0;
                    end
                end
                hduart_pkg::CFG_BIT_COMPARE:  bit_compare_next  = cfg.data;
                hduart_pkg::CFG_FIRST_SAMPLE: first_sample_next = cfg.data;
                hduart_pkg::CFG_CRLF_EXPAND:  crlf_expand_next  = cfg.data[0];
                hduart_pkg::CFG_ECHO_ENABLE:  echo_enable_next  = cfg.data[0];
                default: begin
                end
            endcase
        end else if (evt_valid && enable_reg) begin
            case (evt.cmd)
                hduart_pkg::CMD_SEND: begin
                    send_req = 1'b1;
                    send_b   = evt.tx_byte;
                end
                hduart_pkg::CMD_EDGE: begin
                    if (mode_reg != MODE_RX) begin
                        compare_next    = first_sample_reg;
                        tick_count_next = 8'd0;
                        if (mode_reg != MODE_FREE) begin
                            tx_level_next = 1'b1;
                        end
                        mode_next     = MODE_RX;
                        bit_mask_next = hduart_pkg::MASK_FIRST;
                    end
                end
                hduart_pkg::CMD_TICK: begin
                    if (mode_reg != MODE_FREE) begin
                        if (tick_count_reg != compare_reg) begin
                            tick_count_next = tick_count_reg + 8'd1;
                        end else begin
                            tick_count_next = 8'd0;
                            case (mode_reg)
                                MODE_RX: begin
                                    if (bit_mask_reg == hduart_pkg::MASK_FIRST) begin
                                        compare_next = bit_compare_reg;
                                        shift_v      = 8'd0;
                                    end
                                    if (evt.rx_level) begin
                                        shift_v = shift_v | bit_mask_reg;
                                    end
                                    shift_next = shift_v;
                                    if (bit_mask_reg == hduart_pkg::MASK_LAST) begin
                                        mode_next = MODE_FREE;
                                        got       = 1'b1;
                                        rx_b      = shift_v;
                                        send_req  = echo_enable_reg;
                                        send_b    = shift_v;
                                    end else begin
                                        bit_mask_next = {bit_mask_reg[6:0], 1'b0};
                                    end
                                end
                                MODE_TX: begin
                                    if (bit_mask_reg == hduart_pkg::MASK_NONE) begin
                                        tx_level_next = 1'b1;
                                        mode_next     = MODE_TX_STOP;
                                    end else begin
                                        tx_level_next = |(shift_reg & bit_mask_reg);
                                        bit_mask_next = {bit_mask_reg[6:0], 1'b0};
                                    end
                                end
                                default: begin
                                    // end of stop bit: next queued byte goes out
                                    mode_next = MODE_FREE;
                                    if (count_reg != '0) begin
                                        pop_en   = 1'b1;
                                        start_en = 1'b1;
                                        start_b  = head_data;
                                    end
                                end
                            endcase
                        end
                    end
                end
                default: begin
                end
            endcase

            // send request, from the channel or from echo
            if (send_req) begin
                if (count_reg == FULL_COUNT) begin
                    status = (evt.cmd == hduart_pkg::CMD_SEND);
                end else if (count_reg != '0 || mode_next != MODE_FREE) begin
                    push_en   = 1'b1;
                    push_data = send_b;
                    if (mode_next == MODE_FREE) begin
                        pop_en   = 1'b1;
                        start_en = 1'b1;
                        start_b  = head_data;
                    end
                end else begin
                    start_en = 1'b1;
                    start_b  = send_b;
                end
            end

            if (start_en) begin
                shift_next      = start_b;
                bit_mask_next   = hduart_pkg::MASK_FIRST;
                mode_next       = MODE_TX;
                tx_level_next   = 1'b0;
                tick_count_next = 8'd0;
                compare_next    = bit_compare_reg;
            end

            if (push_en) begin
                tail_next = (tail_reg == LAST_ADDR) ? '0 : tail_reg + QW'(1);
            end
            if (pop_en) begin
                head_next = (head_reg == LAST_ADDR) ? '0 : head_reg + QW'(1);
            end
            count_next = count_reg + CW'(push_en) - CW'(pop_en);
        end

        res.tx_line  = tx_level_next;
        res.rx_valid = got;
        res.rx_byte  = rx_b;
        res.status   = status;
        res.add_lf   = got && crlf_expand_reg && (rx_b == hduart_pkg::CHAR_CR);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg       <= 1'b1;
            bit_compare_reg  <= hduart_pkg::BIT_COMPARE_RST;
            first_sample_reg <= hduart_pkg::FIRST_SAMPLE_RST;
            crlf_expand_reg  <= 1'b1;
            echo_enable_reg  <= 1'b0;
            mode_reg         <= MODE_FREE;
            tick_count_reg   <= 8'd0;
            compare_reg      <= hduart_pkg::BIT_COMPARE_RST;
            bit_mask_reg     <= hduart_pkg::MASK_NONE;
            shift_reg        <= 8'd0;
            tx_level_reg     <= 1'b1;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            bypass_reg       <= 1'b0;
        end else begin
            enable_reg       <= enable_next;
            bit_compare_reg  <= bit_compare_next;
            first_sample_reg <= first_sample_next;
            crlf_expand_reg  <= crlf_expand_next;
            echo_enable_reg  <= echo_enable_next;
            mode_reg         <= mode_next;
            tick_count_reg   <= tick_count_next;
            compare_reg      <= compare_next;
            bit_mask_reg     <= bit_mask_next;
            shift_reg        <= shift_next;
            tx_level_reg     <= tx_level_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            count_reg        <= count_next;
            bypass_reg       <= push_en && (tail_reg == head_next);
        end
        bypass_data_reg <= push_data;
    end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none
module tb;

    localparam int TXQ_DEPTH = 128;
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef enum logic [1:0] {LINE_FREE, LINE_TX, LINE_STOP, LINE_RX} line_mode_t;

    typedef struct packed {
        logic       tx_line;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       status;
        logic       last;
    } uart_result_t;

    typedef struct {
        logic [1:0]   cmd;
        logic         rxl;
        logic [7:0]   data;
        bit           typed;
        uart_result_t res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = hduart_pkg::CMD_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = hduart_pkg::CFG_ENABLE;
    logic [7:0]  cfg_data = '0;

    half_duplex_uart_with_rx_preempt_top #(.TX_QUEUE_DEPTH(TXQ_DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor copy of the registers and the channel state
    logic       reg_enable, reg_crlf, reg_echo;
    logic [7:0] reg_bit_cmp, reg_first_cmp;
    line_mode_t ln_mode;
    logic [7:0] ln_ticks, ln_cmp, ln_mask, ln_shift;
    logic       ln_tx;
    logic [7:0] txq_mem [TXQ_DEPTH];
    logic [6:0] txq_head, txq_tail;
    int         txq_count;

    uart_result_t uart_results_q[$];
    stim_row_t    stim_rows[$];
    int           mismatches = 0;
    bit           steady = 1'b0;
    bit           stall_req = 1'b0;
    logic [7:0]   frame_byte = hduart_pkg::CHAR_CR;

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #60000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void launch_byte(input logic [7:0] b);
        ln_shift = b;
        ln_mask  = hduart_pkg::MASK_FIRST;
        ln_mode  = LINE_TX;
        ln_tx    = 1'b0;
        ln_ticks = '0;
        ln_cmp   = reg_bit_cmp;
    endfunction

    function automatic logic [7:0] dequeue_tx();
        logic [7:0] b;
        b = txq_mem[txq_head];
        txq_head = txq_head + 7'd1;
        txq_count--;
        return b;
    endfunction

    // returns the refusal flag
    function automatic logic request_send(input logic [7:0] b);
        if (txq_count >= TXQ_DEPTH)
            return 1'b1;
        if (txq_count > 0 || ln_mode != LINE_FREE) begin
            txq_mem[txq_tail] = b;
            txq_tail = txq_tail + 7'd1;
            txq_count++;
            if (ln_mode != LINE_FREE)
                return 1'b0;
        end
        if (txq_count > 0)
            launch_byte(dequeue_tx());
        else
            launch_byte(b);
        return 1'b0;
    endfunction

    task automatic predict_uart_event(input logic [1:0] c, input logic r, input logic [7:0] b);
        uart_result_t res;
        logic         refused, got, add_lf;
        logic [7:0]   rx;
        refused = 1'b0;
        got     = 1'b0;
        add_lf  = 1'b0;
        rx      = '0;
        if (reg_enable) begin
            case (c)
                hduart_pkg::CMD_SEND: refused = request_send(b);
                hduart_pkg::CMD_EDGE: if (ln_mode != LINE_RX) begin
                    ln_cmp   = reg_first_cmp;
                    ln_ticks = '0;
                    if (ln_mode != LINE_FREE)
                        ln_tx = 1'b1;
                    ln_mode = LINE_RX;
                    ln_mask = hduart_pkg::MASK_FIRST;
                end
                hduart_pkg::CMD_TICK: if (ln_mode != LINE_FREE) begin
                    if (ln_ticks != ln_cmp) begin
                        ln_ticks = ln_ticks + 8'd1;
                    end else begin
                        ln_ticks = '0;
                        case (ln_mode)
                            LINE_RX: begin
                                if (ln_mask == hduart_pkg::MASK_FIRST) begin
                                    ln_cmp   = reg_bit_cmp;
                                    ln_shift = '0;
                                end
                                if (r)
                                    ln_shift = ln_shift | ln_mask;
                                if (ln_mask == hduart_pkg::MASK_LAST) begin
                                    ln_mode = LINE_FREE;
                                    got     = 1'b1;
                                    rx      = ln_shift;
                                    add_lf  = reg_crlf && (rx == hduart_pkg::CHAR_CR);
                                    // a refused echo is dropped without status
                                    if (reg_echo)
                                        void'(request_send(rx));
                                end else begin
                                    ln_mask = ln_mask << 1;
                                end
                            end
                            LINE_TX: begin
                                if (ln_mask == hduart_pkg::MASK_NONE) begin
                                    ln_tx   = 1'b1;
                                    ln_mode = LINE_STOP;
                                end else begin
                                    ln_tx   = |(ln_shift & ln_mask);
                                    ln_mask = ln_mask << 1;
                                end
                            end
                            default: begin
                                ln_mode = LINE_FREE;
                                if (txq_count > 0)
                                    launch_byte(dequeue_tx());
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
        res = '{ln_tx, got, rx, refused, !add_lf};
        uart_results_q.push_back(res);
        if (add_lf) begin
            res = '{ln_tx, 1'b1, hduart_pkg::CHAR_LF, 1'b0, 1'b1};
            uart_results_q.push_back(res);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        if (r < 4)
            return hduart_pkg::CHAR_CR;
        return 8'($urandom_range(0, 255));
    endfunction

    // offer one event and update the predictor once the transaction is taken
    task automatic offer(input logic [1:0] c, input logic r, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {7'd0, b, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_uart_event(c, r, b);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            hduart_pkg::CFG_ENABLE: begin
                if (d[0] && !reg_enable) begin
                    ln_mode  = LINE_FREE;
                    ln_tx    = 1'b1;
                    ln_ticks = '0;
                end
                reg_enable = d[0];
            end
            hduart_pkg::CFG_BIT_COMPARE:  reg_bit_cmp = d;
            hduart_pkg::CFG_FIRST_SAMPLE: reg_first_cmp = d;
            hduart_pkg::CFG_CRLF_EXPAND:  reg_crlf = d[0];
            hduart_pkg::CFG_ECHO_ENABLE:  reg_echo = d[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (uart_results_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic add_row(input logic [1:0] c, input logic r, input logic [7:0] b,
                           input bit typed, input logic tx);
        stim_row_t row;
        row.cmd   = c;
        row.rxl   = r;
        row.data  = b;
        row.typed = typed;
        row.res   = '{tx, 1'b0, 8'h00, 1'b0, 1'b1};
        stim_rows.push_back(row);
    endtask

    task automatic play_rows();
        foreach (stim_rows[i]) begin
            offer(stim_rows[i].cmd, stim_rows[i].rxl, stim_rows[i].data);
            if (stim_rows[i].typed) begin
                void'(uart_results_q.pop_back());
                uart_results_q.push_back(stim_rows[i].res);
            end
        end
        stim_rows.delete();
    endtask

    task automatic random_events(input int n, input int p_edge, input int p_send);
        int         pick;
        logic [1:0] c;
        logic       r;
        logic [7:0] b;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            b = pick_byte();
            r = 1'($urandom_range(0, 1));
            if (pick < p_edge) begin
                c = hduart_pkg::CMD_EDGE;
                if (ln_mode != LINE_RX)
                    frame_byte = pick_byte();
            end else if (pick < p_edge + p_send) begin
                c = hduart_pkg::CMD_SEND;
            end else if (pick < p_edge + p_send + 2) begin
                c = CMD_NONE;
            end else begin
                c = hduart_pkg::CMD_TICK;
                // follow the frame being received, with a little line noise
                if (ln_mode == LINE_RX && $urandom_range(0, 99) >= 4)
                    r = |(frame_byte & ln_mask);
            end
            offer(c, r, b);
        end
    endtask

    // receiver side: random back-pressure and the occasional long hold-off
    initial begin : sink_ready
        int n;
        forever begin
            if (stall_req) begin
                stall_req = 1'b0;
                m_tready <= 1'b0;
                n = 300;
                repeat (n) @(posedge aclk);
            end else if (!steady && $urandom_range(0, 99) < 25) begin
                m_tready <= 1'b0;
                n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : check_results
        uart_result_t exp_res;
        uart_result_t act_res;
        if (aresetn && m_tvalid && m_tready) begin
            act_res = '{m_tdata[0], m_tuser, m_tdata[8:1], m_tdata[9], m_tlast};
            if (uart_results_q.size() == 0) begin
                $display("%0t: result with nothing expected: expected none, actual %h",
                         $time, act_res);
                mismatches++;
            end else begin
                exp_res = uart_results_q.pop_front();
                if (act_res.tx_line !== exp_res.tx_line) begin
                    $display("%0t: tx_line expected %b actual %b", $time,
                             exp_res.tx_line, act_res.tx_line);
                    mismatches++;
                end
                if (act_res.rx_valid !== exp_res.rx_valid) begin
                    $display("%0t: rx_valid expected %b actual %b", $time,
                             exp_res.rx_valid, act_res.rx_valid);
                    mismatches++;
                end
                if (act_res.rx_byte !== exp_res.rx_byte) begin
                    $display("%0t: rx_byte expected %h actual %h", $time,
                             exp_res.rx_byte, act_res.rx_byte);
                    mismatches++;
                end
                if (act_res.status !== exp_res.status) begin
                    $display("%0t: status expected %b actual %b", $time,
                             exp_res.status, act_res.status);
                    mismatches++;
                end
                if (act_res.last !== exp_res.last) begin
                    $display("%0t: last expected %b actual %b", $time,
                             exp_res.last, act_res.last);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        reg_enable    = 1'b1;
        reg_bit_cmp   = hduart_pkg::BIT_COMPARE_RST;
        reg_first_cmp = hduart_pkg::FIRST_SAMPLE_RST;
        reg_crlf      = 1'b1;
        reg_echo      = 1'b0;
        ln_mode       = LINE_FREE;
        ln_ticks      = '0;
        ln_cmp        = hduart_pkg::BIT_COMPARE_RST;
        ln_mask       = '0;
        ln_shift      = '0;
        ln_tx         = 1'b1;
        txq_head      = '0;
        txq_tail      = '0;
        txq_count     = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults: idle line, start bit, abort by rx edge, queued send
        add_row(hduart_pkg::CMD_TICK, 1'b0, 8'h00, 1'b1, 1'b1);
        add_row(CMD_NONE, 1'b1, 8'hFF, 1'b1, 1'b1);
        add_row(hduart_pkg::CMD_SEND, 1'b0, 8'h00, 1'b1, 1'b0);
        add_row(hduart_pkg::CMD_TICK, 1'b1, 8'hA5, 1'b1, 1'b0);
        add_row(hduart_pkg::CMD_EDGE, 1'b0, 8'h00, 1'b1, 1'b1);
        add_row(hduart_pkg::CMD_SEND, 1'b1, 8'hFF, 1'b1, 1'b1);
        add_row(hduart_pkg::CMD_EDGE, 1'b1, 8'h5A, 1'b1, 1'b1);
        play_rows();

        // close and reopen mid-reception, queue kept; bit and first-sample compares set to one
        settle();
        write_reg(hduart_pkg::CFG_ENABLE, 8'd0);
        write_reg(hduart_pkg::CFG_ENABLE, 8'd1);
        write_reg(hduart_pkg::CFG_BIT_COMPARE, 8'd1);
        write_reg(hduart_pkg::CFG_FIRST_SAMPLE, 8'd1);

        // receive a carriage return, then a send that releases the queued byte
        add_row(hduart_pkg::CMD_EDGE, 1'b0, 8'h00, 1'b0, 1'b0);
        for (int i = 0; i < 8; i++) begin
            add_row(hduart_pkg::CMD_TICK, hduart_pkg::CHAR_CR[i], 8'h00, 1'b0, 1'b0);
            add_row(hduart_pkg::CMD_TICK, hduart_pkg::CHAR_CR[i], 8'hFF, 1'b0, 1'b0);
        end
        add_row(hduart_pkg::CMD_SEND, 1'b0, 8'h55, 1'b0, 1'b0);
        play_rows();

        settle();
        write_reg(hduart_pkg::CFG_FIRST_SAMPLE, 8'd2);
        write_reg(hduart_pkg::CFG_ECHO_ENABLE, 8'd0);
        stall_req = 1'b1;
        random_events(300, 6, 12);

        settle();
        write_reg(hduart_pkg::CFG_BIT_COMPARE, 8'd2);
        write_reg(hduart_pkg::CFG_FIRST_SAMPLE, 8'd4);
        write_reg(hduart_pkg::CFG_CRLF_EXPAND, 8'd0);
        write_reg(hduart_pkg::CFG_ECHO_ENABLE, 8'd1);
        steady = 1'b1;
        random_events(150, 5, 10);
        steady = 1'b0;
        random_events(150, 5, 10);

        settle();
        write_reg(hduart_pkg::CFG_BIT_COMPARE, 8'd255);
        write_reg(hduart_pkg::CFG_FIRST_SAMPLE, 8'd255);
        random_events(200, 1, 8);

        settle();
        write_reg(hduart_pkg::CFG_BIT_COMPARE, 8'd3);
        write_reg(hduart_pkg::CFG_FIRST_SAMPLE, 8'd5);
        write_reg(hduart_pkg::CFG_CRLF_EXPAND, 8'd1);
        write_reg(hduart_pkg::CFG_ENABLE, 8'd0);
        random_events(100, 8, 15);
        settle();
        write_reg(hduart_pkg::CFG_ENABLE, 8'd1);
        random_events(250, 6, 12);

        // overfill the send queue while a reception holds the line
        settle();
        write_reg(hduart_pkg::CFG_BIT_COMPARE, 8'd1);
        write_reg(hduart_pkg::CFG_FIRST_SAMPLE, 8'd1);
        write_reg(hduart_pkg::CFG_ECHO_ENABLE, 8'd0);
        offer(hduart_pkg::CMD_EDGE, 1'b0, 8'h00);
        repeat (140) offer(hduart_pkg::CMD_SEND, 1'($urandom_range(0, 1)), pick_byte());
        stall_req = 1'b1;
        random_events(430, 6, 10);

        settle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
